// ----- rtl/core/nmass_pkg.sv -----
// nmass_pkg: shared widths, constants, codes and structs of the atomic mass estimator
// also holds the elaboration-time builders for the per-mass-number constant tables
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package nmass_pkg;

  localparam int MAX_MASS_NUMBER = 255;
  localparam int A_W             = 8;
  localparam int TAB_DEPTH       = 2 ** A_W;

  // configuration register widths and indexes
  localparam int ME_W       = 12;
  localparam int MP_W       = 21;
  localparam int MN_W       = 21;
  localparam int MD_W       = 22;
  localparam int MA_W       = 23;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ELECTRON = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEUTERON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd4;

  localparam logic [ME_W-1:0] RST_ELECTRON = 12'd511;
  localparam logic [MP_W-1:0] RST_PROTON   = 21'd938272;
  localparam logic [MN_W-1:0] RST_NEUTRON  = 21'd939565;
  localparam logic [MD_W-1:0] RST_DEUTERON = 22'd1875613;
  localparam logic [MA_W-1:0] RST_ALPHA    = 23'd3727379;

  // datapath widths, everything in keV with 16 fractional bits
  localparam int OUT_W   = 28;
  localparam int FRAC_W  = 16;
  localparam int ROOT3_W = 19;
  localparam int ROOT2_W = 21;
  localparam int SURF_W  = 36;
  localparam int PAIR_W  = 30;
  localparam int LIN_W   = 31;
  localparam int SQ_W    = 16;
  localparam int PN_W    = 29;
  localparam int PZ_W    = 30;
  localparam int VOL_W   = 22;
  localparam int NUM_W   = 58;
  localparam int DEN_W   = 19;
  localparam int QUO_W   = 40;
  localparam int SUM_W   = 49;
  localparam int DIV_STAGES = QUO_W;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [13:0] K_VOLUME  = 14'd15670;
  localparam logic [14:0] K_SURFACE = 15'd17230;
  localparam logic [16:0] K_ASYM    = 17'd93150;
  localparam logic [25:0] K_COULOMB = 26'd45773770;
  localparam logic [13:0] K_PAIR    = 14'd12000;

  typedef enum logic [2:0] {
    KIND_INVALID,
    KIND_NEUTRON,
    KIND_HYDROGEN,
    KIND_DEUTERON,
    KIND_ALPHA,
    KIND_FORMULA
  } kind_t;

  typedef enum logic [1:0] {
    PAIR_NONE,
    PAIR_ADD,
    PAIR_SUB
  } pair_mode_t;

  typedef struct packed {
    logic [ME_W-1:0] electron;
    logic [MP_W-1:0] proton;
    logic [MN_W-1:0] neutron;
    logic [MD_W-1:0] deuteron;
    logic [MA_W-1:0] alpha;
  } cfg_t;

  // terms that ride alongside the dividers
  typedef struct packed {
    kind_t                    kind;
    pair_mode_t               pair_mode;
    logic signed [LIN_W-1:0]  lin;
    logic [SURF_W-1:0]        surf;
    logic [PAIR_W-1:0]        pair;
  } side_t;

  // A^(1/3) in Q16, floor
  function automatic logic [ROOT3_W-1:0] cbrt_q16(input int unsigned a);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    x = 64'(a) << 48;
    y = '0;
    for (int b = 20; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t * t <= x) begin
        y = t;
      end
    end
    return y[ROOT3_W-1:0];
  endfunction

  // A^(1/2) in Q16, floor
  function automatic logic [ROOT2_W-1:0] sqrt_q16(input int unsigned a);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    x = 64'(a) << 32;
    y = '0;
    for (int b = 21; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t <= x) begin
        y = t;
      end
    end
    return y[ROOT2_W-1:0];
  endfunction

  function automatic logic [SURF_W-1:0] surface_q16(input int unsigned a);
    logic [63:0] c;
    logic [63:0] v;
    c = 64'(cbrt_q16(a));
    v = (64'(K_SURFACE) * c * c + 64'd32768) >> 16;
    return v[SURF_W-1:0];
  endfunction

  // round(12000 * 2^32 / sqrt), long division bit by bit
  function automatic logic [PAIR_W-1:0] pair_q16(input int unsigned a);
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    s   = 64'(sqrt_q16(a));
    num = (64'(K_PAIR) << 32) + (s >> 1);
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (s != '0 && rem >= s) begin
        rem  = rem - s;
        q[b] = 1'b1;
      end
    end
    return q[PAIR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nmass_prep.sv -----
// nmass_prep: three front stages - decode and table lookup, squares and products,
// divider numerators and the linear term
// depends on nmass_pkg
`timescale 1ns / 1ps
`default_nettype none
module nmass_prep (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              in_vld,
  input  wire logic [nmass_pkg::A_W-1:0]         mass_number,
  input  wire logic [nmass_pkg::A_W-1:0]         charge_number,
  input  wire nmass_pkg::cfg_t                   cfg,
  output logic                                   p_vld,
  output nmass_pkg::side_t                       p_side,
  output logic [nmass_pkg::NUM_W-1:0]            asym_num,
  output logic [nmass_pkg::DEN_W-1:0]            asym_den,
  output logic [nmass_pkg::NUM_W-1:0]            coul_num,
  output logic [nmass_pkg::DEN_W-1:0]            coul_den
);

  logic [nmass_pkg::ROOT3_W-1:0] cbrt_rom [nmass_pkg::TAB_DEPTH];
  logic [nmass_pkg::SURF_W-1:0]  surf_rom [nmass_pkg::TAB_DEPTH];
  logic [nmass_pkg::PAIR_W-1:0]  pair_rom [nmass_pkg::TAB_DEPTH];

  for (genvar g = 0; g < nmass_pkg::TAB_DEPTH; g++) begin : g_rom
    localparam logic [nmass_pkg::ROOT3_W-1:0] CBRT = nmass_pkg::cbrt_q16(g);
    localparam logic [nmass_pkg::SURF_W-1:0]  SURF = nmass_pkg::surface_q16(g);
    localparam logic [nmass_pkg::PAIR_W-1:0]  PAIR = nmass_pkg::pair_q16(g);
    assign cbrt_rom[g] = CBRT;
    assign surf_rom[g] = SURF;
    assign pair_rom[g] = PAIR;
  end

  // stage 1: decode, |A-2Z|, table reads
  nmass_pkg::kind_t              kind_nxt;
  nmass_pkg::pair_mode_t         pm_nxt;
  logic [nmass_pkg::A_W-1:0]     n_nxt;
  logic [nmass_pkg::A_W:0]       z2x;
  logic [nmass_pkg::A_W:0]       d_full;
  logic                          mass_over;

  logic                          v1_r;
  nmass_pkg::kind_t              kind1_r;
  nmass_pkg::pair_mode_t         pm1_r;
  logic [nmass_pkg::A_W-1:0]     a1_r;
  logic [nmass_pkg::A_W-1:0]     z1_r;
  logic [nmass_pkg::A_W-1:0]     n1_r;
  logic [nmass_pkg::A_W-1:0]     d1_r;
  logic [nmass_pkg::ROOT3_W-1:0] c1_r;
  logic [nmass_pkg::SURF_W-1:0]  surf1_r;
  logic [nmass_pkg::PAIR_W-1:0]  pair1_r;

  always_comb begin
    n_nxt     = mass_number - charge_number;
    z2x       = {charge_number, 1'b0};
    mass_over = {1'b0, mass_number} > (nmass_pkg::A_W + 1)'(nmass_pkg::MAX_MASS_NUMBER);
    if (z2x > {1'b0, mass_number}) begin
      d_full = z2x - {1'b0, mass_number};
    end else begin
      d_full = {1'b0, mass_number} - z2x;
    end
    if (mass_number == '0 || mass_over || charge_number > mass_number) begin
      kind_nxt = nmass_pkg::KIND_INVALID;
    end else if (mass_number == 8'd1 && charge_number == 8'd0) begin
      kind_nxt = nmass_pkg::KIND_NEUTRON;
    end else if (mass_number == 8'd1) begin
      kind_nxt = nmass_pkg::KIND_HYDROGEN;
    end else if (mass_number == 8'd2 && charge_number == 8'd1) begin
      kind_nxt = nmass_pkg::KIND_DEUTERON;
    end else if (mass_number == 8'd4 && charge_number == 8'd2) begin
      kind_nxt = nmass_pkg::KIND_ALPHA;
    end else begin
      kind_nxt = nmass_pkg::KIND_FORMULA;
    end
    // pairing only when N and Z share parity: odd-odd adds, even-even subtracts
    if (n_nxt[0] != charge_number[0]) begin
      pm_nxt = nmass_pkg::PAIR_NONE;
    end else if (charge_number[0]) begin
      pm_nxt = nmass_pkg::PAIR_ADD;
    end else begin
      pm_nxt = nmass_pkg::PAIR_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= kind_nxt;
      pm1_r   <= pm_nxt;
      a1_r    <= mass_number;
      z1_r    <= charge_number;
      n1_r    <= n_nxt;
      d1_r    <= d_full[nmass_pkg::A_W-1:0];
      c1_r    <= cbrt_rom[mass_number];
      surf1_r <= surf_rom[mass_number];
      pair1_r <= pair_rom[mass_number];
    end
  end

  // stage 2: squares and the mass products
  logic [nmass_pkg::MP_W:0]      mpe;
  logic                          v2_r;
  nmass_pkg::kind_t              kind2_r;
  nmass_pkg::pair_mode_t         pm2_r;
  logic [nmass_pkg::A_W-1:0]     a2_r;
  logic [nmass_pkg::ROOT3_W-1:0] c2_r;
  logic [nmass_pkg::SURF_W-1:0]  surf2_r;
  logic [nmass_pkg::PAIR_W-1:0]  pair2_r;
  logic [nmass_pkg::SQ_W-1:0]    zsq2_r;
  logic [nmass_pkg::SQ_W-1:0]    dsq2_r;
  logic [nmass_pkg::PN_W-1:0]    pn2_r;
  logic [nmass_pkg::PZ_W-1:0]    pz2_r;
  logic [nmass_pkg::VOL_W-1:0]   vol2_r;

  assign mpe = {1'b0, cfg.proton} + (nmass_pkg::MP_W + 1)'(cfg.electron);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2_r <= kind1_r;
      pm2_r   <= pm1_r;
      a2_r    <= a1_r;
      c2_r    <= c1_r;
      surf2_r <= surf1_r;
      pair2_r <= pair1_r;
      zsq2_r  <= {8'b0, z1_r} * {8'b0, z1_r};
      dsq2_r  <= {8'b0, d1_r} * {8'b0, d1_r};
      pn2_r   <= {21'b0, n1_r} * {8'b0, cfg.neutron};
      pz2_r   <= {22'b0, z1_r} * {8'b0, mpe};
      vol2_r  <= {8'b0, nmass_pkg::K_VOLUME} * {14'b0, a1_r};
    end
  end

  // stage 3: divider numerators with half the divisor added for rounding
  logic [41:0]                  coul_prod;
  logic [32:0]                  asym_prod;
  logic [nmass_pkg::NUM_W-1:0]  coul_num_nxt;
  logic [nmass_pkg::NUM_W-1:0]  asym_num_nxt;
  logic signed [nmass_pkg::LIN_W-1:0] lin_nxt;
  logic                         v3_r;
  nmass_pkg::side_t             side3_r;
  logic [nmass_pkg::NUM_W-1:0]  asym_num_r;
  logic [nmass_pkg::DEN_W-1:0]  asym_den_r;
  logic [nmass_pkg::NUM_W-1:0]  coul_num_r;
  logic [nmass_pkg::DEN_W-1:0]  coul_den_r;

  always_comb begin
    coul_prod    = {16'b0, nmass_pkg::K_COULOMB} * {26'b0, zsq2_r};
    asym_prod    = {16'b0, nmass_pkg::K_ASYM} * {17'b0, dsq2_r};
    coul_num_nxt = {coul_prod, 16'b0} + {40'b0, c2_r[nmass_pkg::ROOT3_W-1:1]};
    asym_num_nxt = {11'b0, asym_prod, 14'b0} + {51'b0, a2_r[nmass_pkg::A_W-1:1]};
    lin_nxt      = $signed({2'b0, pn2_r}) + $signed({1'b0, pz2_r})
                 - $signed({9'b0, vol2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r.kind      <= kind2_r;
      side3_r.pair_mode <= pm2_r;
      side3_r.lin       <= lin_nxt;
      side3_r.surf      <= surf2_r;
      side3_r.pair      <= pair2_r;
      asym_num_r        <= asym_num_nxt;
      asym_den_r        <= {11'b0, a2_r};
      coul_num_r        <= coul_num_nxt;
      coul_den_r        <= c2_r;
    end
  end

  assign p_vld    = v3_r;
  assign p_side   = side3_r;
  assign asym_num = asym_num_r;
  assign asym_den = asym_den_r;
  assign coul_num = coul_num_r;
  assign coul_den = coul_den_r;

endmodule
`default_nettype wire

// ----- rtl/core/nmass_div.sv -----
// nmass_div: pipelined restoring divider, one quotient bit per stage
// quotient must fit QUO_W bits (numerator high part below the divisor); depends on nmass_pkg
`timescale 1ns / 1ps
`default_nettype none
module nmass_div (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic [nmass_pkg::NUM_W-1:0]   num,
  input  wire logic [nmass_pkg::DEN_W-1:0]   den,
  output logic [nmass_pkg::QUO_W-1:0]        quo
);

  localparam int LAST = nmass_pkg::DIV_STAGES - 1;

  logic [nmass_pkg::DEN_W-1:0] rem_r [LAST];
  logic [nmass_pkg::DEN_W-1:0] den_r [LAST];
  // low numerator bits shift out at the top while quotient bits shift in below
  logic [nmass_pkg::QUO_W-1:0] lq_r  [nmass_pkg::DIV_STAGES];

  for (genvar k = 0; k < nmass_pkg::DIV_STAGES; k++) begin : g_stage
    logic [nmass_pkg::DEN_W-1:0] rem_cur;
    logic [nmass_pkg::DEN_W-1:0] den_cur;
    logic [nmass_pkg::QUO_W-1:0] lq_cur;
    logic [nmass_pkg::DEN_W:0]   trial;
    logic [nmass_pkg::DEN_W:0]   diff;
    logic                        ge;
    logic [nmass_pkg::QUO_W-1:0] lq_nxt;

    if (k == 0) begin : g_first
      assign rem_cur = nmass_pkg::DEN_W'(num[nmass_pkg::NUM_W-1:nmass_pkg::QUO_W]);
      assign den_cur = den;
      assign lq_cur  = num[nmass_pkg::QUO_W-1:0];
    end else begin : g_next
      assign rem_cur = rem_r[k-1];
      assign den_cur = den_r[k-1];
      assign lq_cur  = lq_r[k-1];
    end

    assign trial  = {rem_cur, lq_cur[nmass_pkg::QUO_W-1]};
    assign ge     = trial >= {1'b0, den_cur};
    assign diff   = trial - {1'b0, den_cur};
    assign lq_nxt = {lq_cur[nmass_pkg::QUO_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (adv) begin
        lq_r[k] <= lq_nxt;
      end
    end

    if (k < LAST) begin : g_carry
      logic [nmass_pkg::DEN_W-1:0] rem_nxt;
      assign rem_nxt = ge ? diff[nmass_pkg::DEN_W-1:0] : trial[nmass_pkg::DEN_W-1:0];
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_cur;
        end
      end
    end
  end

  assign quo = lq_r[LAST];

endmodule
`default_nettype wire

// ----- rtl/core/nmass_post.sv -----
// nmass_post: sums the liquid-drop terms, rounds to keV, saturates and picks the
// configured mass for the light special nuclei; holds the output register; depends on nmass_pkg
`timescale 1ns / 1ps
`default_nettype none
module nmass_post (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          d_vld,
  input  wire nmass_pkg::side_t              d_side,
  input  wire logic [nmass_pkg::QUO_W-1:0]   asym_q,
  input  wire logic [nmass_pkg::QUO_W-1:0]   coul_q,
  input  wire nmass_pkg::cfg_t               cfg,
  output logic                               out_vld,
  output logic [nmass_pkg::OUT_W-1:0]        out_mass,
  output logic                               out_ok
);

  localparam int SW = nmass_pkg::SUM_W;

  // stage 1: two partial sums
  logic [SW-1:0]    lin_q16;
  logic [SW-1:0]    pos_terms;
  logic [SW-1:0]    pair_ext;
  logic [SW-1:0]    t2_nxt;
  logic             v1_r;
  nmass_pkg::kind_t kind1_r;
  logic [SW-1:0]    t1_r;
  logic [SW-1:0]    t2_r;

  always_comb begin
    lin_q16   = {{(SW - nmass_pkg::LIN_W - nmass_pkg::FRAC_W){d_side.lin[nmass_pkg::LIN_W-1]}},
                 d_side.lin, {nmass_pkg::FRAC_W{1'b0}}};
    pos_terms = SW'(asym_q) + SW'(coul_q);
    pair_ext  = SW'(d_side.pair);
    case (d_side.pair_mode)
      nmass_pkg::PAIR_ADD: t2_nxt = pos_terms + pair_ext;
      nmass_pkg::PAIR_SUB: t2_nxt = pos_terms - pair_ext;
      default:             t2_nxt = pos_terms;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= d_side.kind;
      t1_r    <= lin_q16 + SW'(d_side.surf);
      t2_r    <= t2_nxt;
    end
  end

  // stage 2: full signed sum
  logic             v2_r;
  nmass_pkg::kind_t kind2_r;
  logic [SW-1:0]    sum2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2_r <= kind1_r;
      sum2_r  <= t1_r + t2_r;
    end
  end

  // stage 3: round half up, clamp at zero and at full scale, special nuclei
  logic [SW-1:0]                  rounded;
  logic [SW-nmass_pkg::FRAC_W-1:0] kev;
  logic [nmass_pkg::OUT_W-1:0]    formula_kev;
  logic [nmass_pkg::OUT_W-1:0]    mass_nxt;
  logic                           ok_nxt;
  logic                           out_vld_r;
  logic [nmass_pkg::OUT_W-1:0]    out_mass_r;
  logic                           out_ok_r;

  always_comb begin
    rounded = sum2_r + SW'(1 << (nmass_pkg::FRAC_W - 1));
    kev     = rounded[SW-1:nmass_pkg::FRAC_W];
    if (sum2_r[SW-1]) begin
      formula_kev = '0;
    end else if (kev > (SW - nmass_pkg::FRAC_W)'(nmass_pkg::OUT_MAX)) begin
      formula_kev = nmass_pkg::OUT_MAX;
    end else begin
      formula_kev = kev[nmass_pkg::OUT_W-1:0];
    end
    ok_nxt = 1'b1;
    case (kind2_r)
      nmass_pkg::KIND_NEUTRON:  mass_nxt = nmass_pkg::OUT_W'(cfg.neutron);
      nmass_pkg::KIND_HYDROGEN: mass_nxt = nmass_pkg::OUT_W'(cfg.proton)
                                         + nmass_pkg::OUT_W'(cfg.electron);
      nmass_pkg::KIND_DEUTERON: mass_nxt = nmass_pkg::OUT_W'(cfg.deuteron)
                                         + nmass_pkg::OUT_W'(cfg.electron);
      nmass_pkg::KIND_ALPHA:    mass_nxt = nmass_pkg::OUT_W'(cfg.alpha)
                                         + nmass_pkg::OUT_W'({cfg.electron, 1'b0});
      nmass_pkg::KIND_FORMULA:  mass_nxt = formula_kev;
      default: begin
        mass_nxt = '0;
        ok_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mass_r <= mass_nxt;
      out_ok_r   <= ok_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_mass = out_mass_r;
  assign out_ok   = out_ok_r;

endmodule
`default_nettype wire

// ----- rtl/core/nuclear_atomic_mass_estimator_unit.sv -----
// throughput: one request per cycle unless a refused result stalls the pipe; the two 40-stage dividers set the depth
// a stalled result freezes the whole pipe, so in_stall follows out_valid and out_stall
// reset: synchronous, active low; clears every valid bit and reloads default masses
// depends on nmass_pkg, nmass_prep, nmass_div, nmass_post
`timescale 1ns / 1ps
`default_nettype none
module nuclear_atomic_mass_estimator_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [nmass_pkg::A_W-1:0]           in_mass_number,
  input  wire logic [nmass_pkg::A_W-1:0]           in_charge_number,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [nmass_pkg::OUT_W-1:0]              out_atomic_mass_kev,
  output logic                                     out_valid_res,
  input  wire logic                                cfg_we,
  input  wire logic [nmass_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nmass_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  nmass_pkg::cfg_t cfg_r;
  logic            adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.electron <= nmass_pkg::RST_ELECTRON;
      cfg_r.proton   <= nmass_pkg::RST_PROTON;
      cfg_r.neutron  <= nmass_pkg::RST_NEUTRON;
      cfg_r.deuteron <= nmass_pkg::RST_DEUTERON;
      cfg_r.alpha    <= nmass_pkg::RST_ALPHA;
    end else if (cfg_we) begin
      case (cfg_index)
        nmass_pkg::CFG_ELECTRON: cfg_r.electron <= cfg_wdata[nmass_pkg::ME_W-1:0];
        nmass_pkg::CFG_PROTON:   cfg_r.proton   <= cfg_wdata[nmass_pkg::MP_W-1:0];
        nmass_pkg::CFG_NEUTRON:  cfg_r.neutron  <= cfg_wdata[nmass_pkg::MN_W-1:0];
        nmass_pkg::CFG_DEUTERON: cfg_r.deuteron <= cfg_wdata[nmass_pkg::MD_W-1:0];
        nmass_pkg::CFG_ALPHA:    cfg_r.alpha    <= cfg_wdata[nmass_pkg::MA_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output holds a result the consumer refuses
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic                        p_vld;
  nmass_pkg::side_t            p_side;
  logic [nmass_pkg::NUM_W-1:0] asym_num;
  logic [nmass_pkg::DEN_W-1:0] asym_den;
  logic [nmass_pkg::NUM_W-1:0] coul_num;
  logic [nmass_pkg::DEN_W-1:0] coul_den;
  logic [nmass_pkg::QUO_W-1:0] asym_q;
  logic [nmass_pkg::QUO_W-1:0] coul_q;

  nmass_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_vld        (in_valid),
    .mass_number   (in_mass_number),
    .charge_number (in_charge_number),
    .cfg           (cfg_r),
    .p_vld         (p_vld),
    .p_side        (p_side),
    .asym_num      (asym_num),
    .asym_den      (asym_den),
    .coul_num      (coul_num),
    .coul_den      (coul_den)
  );

  nmass_div u_div_asym (
    .clk (clk),
    .adv (adv),
    .num (asym_num),
    .den (asym_den),
    .quo (asym_q)
  );

  nmass_div u_div_coul (
    .clk (clk),
    .adv (adv),
    .num (coul_num),
    .den (coul_den),
    .quo (coul_q)
  );

  // side terms and valid bits walk beside the divider stages
  logic             vld_d_r  [nmass_pkg::DIV_STAGES];
  nmass_pkg::side_t side_d_r [nmass_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nmass_pkg::DIV_STAGES; i++) begin
        vld_d_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_d_r[0] <= p_vld;
      for (int i = 1; i < nmass_pkg::DIV_STAGES; i++) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d_r[0] <= p_side;
      for (int i = 1; i < nmass_pkg::DIV_STAGES; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  nmass_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .d_vld    (vld_d_r[nmass_pkg::DIV_STAGES-1]),
    .d_side   (side_d_r[nmass_pkg::DIV_STAGES-1]),
    .asym_q   (asym_q),
    .coul_q   (coul_q),
    .cfg      (cfg_r),
    .out_vld  (out_valid),
    .out_mass (out_atomic_mass_kev),
    .out_ok   (out_valid_res)
  );

endmodule
`default_nettype wire

// ----- rtl/core/nmass_checker.sv -----
// nmass_checker: port-level checks of the atomic mass estimator, bound to the top level
// depends on nmass_pkg and nuclear_atomic_mass_estimator_unit
`timescale 1ns / 1ps
`default_nettype none
module nmass_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [nmass_pkg::OUT_W-1:0]       out_atomic_mass_kev,
  input wire logic                              out_valid_res
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_atomic_mass_kev)
                               && $stable(out_valid_res))
    else $error("stalled result changed");

  // the input only backs up behind a refused result
  a_stall_cause: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a refused result");

  // invalid nuclei always report zero mass
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_atomic_mass_kev == '0)
    else $error("invalid nucleus with nonzero mass");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // a request offered while the output is empty is never stalled
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

endmodule

bind nuclear_atomic_mass_estimator_unit nmass_checker u_nmass_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_atomic_mass_kev (out_atomic_mass_kev),
  .out_valid_res       (out_valid_res)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for nuclear_atomic_mass_estimator_unit: directed and random nuclei under several
// particle mass settings, each result checked against an in-bench liquid-drop mass predictor
// depends on nmass_pkg and the estimator rtl
`timescale 1ns / 1ps
module testbench;
  import nmass_pkg::*;

  localparam int PIPE_LATENCY = 45;
  localparam int TIMEOUT_NS   = 400000;

  localparam longint unsigned VOLUME_KEV  = 15670;
  localparam longint unsigned SURFACE_KEV = 17230;
  localparam longint unsigned ASYM_KEV    = 93150;
  localparam longint unsigned COULOMB_Q16 = 45773770;
  localparam longint unsigned PAIRING_KEV = 12000;
  localparam longint          MASS_LIMIT  = (longint'(1) << OUT_W) - 1;

  localparam cfg_t RESET_MASSES = '{electron: RST_ELECTRON, proton: RST_PROTON,
                                    neutron: RST_NEUTRON, deuteron: RST_DEUTERON,
                                    alpha: RST_ALPHA};

  typedef struct {
    logic [A_W-1:0]   mass_number;
    logic [A_W-1:0]   charge_number;
    logic [OUT_W-1:0] atomic_mass_kev;
    logic             valid_res;
  } nucleus_mass_t;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [A_W-1:0]        in_mass_number   = '0;
  logic [A_W-1:0]        in_charge_number = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [OUT_W-1:0]      out_atomic_mass_kev;
  logic                  out_valid_res;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

  cfg_t          masses = RESET_MASSES;
  nucleus_mass_t awaited_masses[$];
  bit            no_idle;
  int            error_count;
  int            requests_sent;
  int            results_checked;
  int            settings_loaded;

  nuclear_atomic_mass_estimator_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mass_number      (in_mass_number),
    .in_charge_number    (in_charge_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_atomic_mass_kev (out_atomic_mass_kev),
    .out_valid_res       (out_valid_res),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit take_break();
    return !no_idle && ($urandom_range(99) < 20);
  endfunction

  // floor of the k-th root (k = 2 or 3) by bisection, roots stay below 2^21
  function automatic longint unsigned int_root(input longint unsigned x, input int k);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    lo = 0;
    hi = longint'(1) << 21;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      p = mid * mid;
      if (k == 3) begin
        p = p * mid;
      end
      if (p <= x) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic nucleus_mass_t predict_atomic_mass(input logic [A_W-1:0] a,
                                                        input logic [A_W-1:0] z);
    nucleus_mass_t   r;
    kind_t           kind;
    longint unsigned av, zv, nv, diff, root3, root2, surf, asym, coul, pair;
    longint          lin, total;
    av = a;
    zv = z;
    r.mass_number   = a;
    r.charge_number = z;
    if (av == 0 || av > MAX_MASS_NUMBER || zv > av) begin
      kind = KIND_INVALID;
    end else if (av == 1) begin
      kind = (zv == 0) ? KIND_NEUTRON : KIND_HYDROGEN;
    end else if (av == 2 && zv == 1) begin
      kind = KIND_DEUTERON;
    end else if (av == 4 && zv == 2) begin
      kind = KIND_ALPHA;
    end else begin
      kind = KIND_FORMULA;
    end
    case (kind)
      KIND_INVALID:  total = 0;
      KIND_NEUTRON:  total = masses.neutron;
      KIND_HYDROGEN: total = masses.proton + masses.electron;
      KIND_DEUTERON: total = masses.deuteron + masses.electron;
      KIND_ALPHA:    total = masses.alpha + 2 * masses.electron;
      default: begin
        // liquid drop, all terms in keV with 16 fractional bits
        nv    = av - zv;
        root3 = int_root(av << 48, 3);
        root2 = int_root(av << 32, 2);
        diff  = (2 * zv > av) ? 2 * zv - av : av - 2 * zv;
        surf  = (SURFACE_KEV * root3 * root3 + 32768) >> 16;
        asym  = (ASYM_KEV * diff * diff * 16384 + av / 2) / av;
        coul  = (COULOMB_Q16 * zv * zv * 65536 + root3 / 2) / root3;
        pair  = ((PAIRING_KEV << 32) + root2 / 2) / root2;
        lin   = longint'(nv * masses.neutron)
              + longint'(zv * (masses.proton + masses.electron))
              - longint'(VOLUME_KEV * av);
        total = lin * 65536 + longint'(surf + asym + coul);
        if (nv[0] == zv[0]) begin
          total = zv[0] ? total + longint'(pair) : total - longint'(pair);
        end
        total = (total < 0) ? 0 : (total + 32768) >>> 16;
      end
    endcase
    r.valid_res       = (kind != KIND_INVALID);
    r.atomic_mass_kev = (total > MASS_LIMIT) ? OUT_MAX : total[OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_nucleus(input logic [A_W-1:0] a, input logic [A_W-1:0] z);
    nucleus_mass_t want;
    want = predict_atomic_mass(a, z);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mass_number   <= a;
    in_charge_number <= z;
    do @(posedge clk); while (in_stall);
    awaited_masses.push_back(want);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_masses.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // upper data bits beyond each register's width are random, the block must drop them
  task automatic load_masses(input cfg_t m, input bit poke_unused);
    logic [CFG_DATA_W-1:0] wdata;
    int unsigned           idx;
    for (idx = 0; idx < 2 ** CFG_IDX_W; idx++) begin
      if (idx > CFG_ALPHA && !poke_unused) begin
        break;
      end
      wdata = CFG_DATA_W'($urandom());
      case (idx)
        CFG_ELECTRON: wdata[ME_W-1:0] = m.electron;
        CFG_PROTON:   wdata[MP_W-1:0] = m.proton;
        CFG_NEUTRON:  wdata[MN_W-1:0] = m.neutron;
        CFG_DEUTERON: wdata[MD_W-1:0] = m.deuteron;
        CFG_ALPHA:    wdata[MA_W-1:0] = m.alpha;
        default: ;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_wdata <= wdata;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    masses = m;
    settings_loaded++;
  endtask

  function automatic cfg_t random_masses();
    cfg_t m;
    m.electron = ($urandom_range(2) == 0) ? RST_ELECTRON : ME_W'($urandom());
    m.proton   = ($urandom_range(2) == 0) ? RST_PROTON   : MP_W'($urandom());
    m.neutron  = ($urandom_range(2) == 0) ? RST_NEUTRON  : MN_W'($urandom());
    m.deuteron = ($urandom_range(2) == 0) ? RST_DEUTERON : MD_W'($urandom());
    m.alpha    = ($urandom_range(2) == 0) ? RST_ALPHA    : MA_W'($urandom());
    return m;
  endfunction

  // special nuclei, invalid pairs, pairing parities and field extremes at default masses
  task automatic test_reset_masses();
    load_masses(RESET_MASSES, 1'b1);
    send_nucleus(8'd1, 8'd0);
    send_nucleus(8'd1, 8'd1);
    send_nucleus(8'd2, 8'd1);
    send_nucleus(8'd4, 8'd2);
    send_nucleus(8'd0, 8'd0);
    send_nucleus(8'd0, 8'd255);
    send_nucleus(8'd1, 8'd2);
    send_nucleus(8'd127, 8'd128);
    send_nucleus(8'd2, 8'd0);
    send_nucleus(8'd2, 8'd2);
    send_nucleus(8'd6, 8'd3);
    send_nucleus(8'd12, 8'd6);
    send_nucleus(8'd255, 8'd0);
    send_nucleus(8'd255, 8'd255);
    send_nucleus(8'd170, 8'd85);
    send_nucleus(8'd85, 8'd42);
    wait_drained();
  endtask

  // full-scale masses saturate heavy nuclei, zero masses drive the sum below zero
  task automatic test_mass_extremes();
    load_masses('1, 1'b0);
    send_nucleus(8'd1, 8'd1);
    send_nucleus(8'd4, 8'd2);
    send_nucleus(8'd255, 8'd0);
    send_nucleus(8'd255, 8'd255);
    send_nucleus(8'd200, 8'd99);
    wait_drained();
    load_masses('0, 1'b1);
    send_nucleus(8'd1, 8'd0);
    send_nucleus(8'd2, 8'd1);
    send_nucleus(8'd255, 8'd118);
    send_nucleus(8'd200, 8'd90);
    send_nucleus(8'd64, 8'd28);
    wait_drained();
  endtask

  task automatic test_random_nuclei();
    logic [A_W-1:0] a, z;
    int             pick;
    for (int phase = 0; phase < 6; phase++) begin
      load_masses((phase == 0) ? RESET_MASSES : random_masses(), 1'($urandom_range(1)));
      no_idle = (phase == 3);
      for (int i = 0; i < 120; i++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          a = A_W'($urandom_range(1, MAX_MASS_NUMBER));
          z = A_W'($urandom_range(0, a));
        end else if (pick < 85) begin
          case ($urandom_range(3))
            0:       begin a = 8'd1; z = 8'd0; end
            1:       begin a = 8'd1; z = 8'd1; end
            2:       begin a = 8'd2; z = 8'd1; end
            default: begin a = 8'd4; z = 8'd2; end
          endcase
        end else begin
          a = A_W'($urandom());
          z = A_W'($urandom());
        end
        send_nucleus(a, z);
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    nucleus_mass_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (awaited_masses.size() == 0) begin
          report_mismatch($sformatf("result mass=%0d with no request pending",
                                    out_atomic_mass_kev));
        end else begin
          want = awaited_masses.pop_front();
          results_checked++;
          if (out_atomic_mass_kev !== want.atomic_mass_kev) begin
            report_mismatch($sformatf("A=%0d Z=%0d mass got %0d want %0d",
                                      want.mass_number, want.charge_number,
                                      out_atomic_mass_kev, want.atomic_mass_kev));
          end
          if (out_valid_res !== want.valid_res) begin
            report_mismatch($sformatf("A=%0d Z=%0d valid_res got %b want %b",
                                      want.mass_number, want.charge_number,
                                      out_valid_res, want.valid_res));
          end
        end
      end
      out_stall <= take_break();
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_masses();
    test_mass_extremes();
    test_random_nuclei();
    $display("%0d nuclei sent under %0d mass settings, %0d results checked, %0d errors",
             requests_sent, settings_loaded, results_checked, error_count);
    if (error_count == 0) begin
      $display("nuclear_atomic_mass_estimator_unit test passed");
    end else begin
      $display("nuclear_atomic_mass_estimator_unit test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", awaited_masses.size());
    $display("nuclear_atomic_mass_estimator_unit test failed");
    $finish;
  end

endmodule
